// ===== hdl/svna_pkg.sv =====
// shared types and codes for the smooth vertex normal accumulator
package svna_pkg;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_TRI   = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [9:0]         vertex_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [9:0]         corner_a;
      logic [9:0]         corner_b;
      logic [9:0]         corner_c;
   } svna_req_type;

   typedef struct packed {
      logic [9:0]         out_index;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic               degenerate;
   } svna_rsp_type;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_TRI,
      OP_READ,
      OP_READ_BAD
   } svna_op_type;

   typedef struct packed {
      svna_op_type        op;
      logic [9:0]         index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [9:0]         corner_a;
      logic [9:0]         corner_b;
      logic [9:0]         corner_c;
   } svna_cmd_type;

   typedef struct packed {
      logic               valid;
      logic               degenerate;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
   } svna_nres_type;

endpackage

// ===== hdl/svna_front.sv =====
// front end: takes request beats, checks indices and queues commands
module svna_front #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  svna_pkg::svna_req_type req_data,
   output logic                  q_valid,
   output svna_pkg::svna_cmd_type q_cmd,
   input  logic                  q_pop
);
   import svna_pkg::*;

   localparam logic [16:0] Lim = 17'(MAX_VERTICES);

   svna_cmd_type entry_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;
   svna_cmd_type cmd_in;
   logic         push_ok, push_en, pop_en, accept;
   logic         idx_ok, a_ok, b_ok, c_ok;

   assign idx_ok = 17'(req_data.vertex_index) < Lim;
   assign a_ok   = 17'(req_data.corner_a) < Lim;
   assign b_ok   = 17'(req_data.corner_b) < Lim;
   assign c_ok   = 17'(req_data.corner_c) < Lim;

   always_comb begin
      cmd_in.index    = req_data.vertex_index;
      cmd_in.pos_x    = req_data.pos_x;
      cmd_in.pos_y    = req_data.pos_y;
      cmd_in.pos_z    = req_data.pos_z;
      cmd_in.corner_a = req_data.corner_a;
      cmd_in.corner_b = req_data.corner_b;
      cmd_in.corner_c = req_data.corner_c;
      cmd_in.op       = OP_WRITE;
      push_ok         = 1'b0;
      case (req_data.kind)
         KIND_WRITE: begin
            push_ok = idx_ok;
         end
         KIND_TRI: begin
            cmd_in.op = OP_TRI;
            push_ok   = a_ok && b_ok && c_ok;
         end
         KIND_READ: begin
            cmd_in.op = idx_ok ? OP_READ : OP_READ_BAD;
            push_ok   = 1'b1;
         end
         default: begin
            push_ok = 1'b0;
         end
      endcase
   end

   assign req_ready = enable && (count_ff != 2'd2);
   assign accept    = req_valid && req_ready;
   assign push_en   = accept && push_ok;
   assign q_valid   = count_ff != 2'd0;
   assign pop_en    = q_pop && q_valid;
   assign q_cmd     = entry_ff[rd_ptr_ff];
   assign count_in  = count_ff + 2'(push_en) - 2'(pop_en);

   always_ff @(posedge clock) begin
      if (push_en) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_en) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_en) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/svna_norm.sv =====
// iterative vector normalizer: shift search, sum of squares, root, divide
module svna_norm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [63:0]     vec_x,
   input  logic signed [63:0]     vec_y,
   input  logic signed [63:0]     vec_z,
   output svna_pkg::svna_nres_type res
);
   import svna_pkg::*;

   typedef enum logic [2:0] {
      N_IDLE,
      N_SHIFT,
      N_SQ,
      N_SQRT,
      N_PREP,
      N_DIV,
      N_OUT
   } nstate_type;

   localparam logic [62:0] T38 = 63'(1) << 38;
   localparam logic [62:0] T30 = 63'(1) << 30;
   localparam logic [62:0] T29 = 63'(1) << 29;
   localparam logic [62:0] T22 = 63'(1) << 22;

   nstate_type    state_ff;
   logic [62:0]   m_ff [3];
   logic          neg_ff [3];
   logic [1:0]    step_ff;
   logic [59:0]   sq_ff;
   logic [61:0]   x_ff, root_ff, bit_ff;
   logic [44:0]   rem_ff [3];
   logic [14:0]   q_ff [3];
   logic [3:0]    k_ff;
   svna_nres_type res_ff;
   logic [62:0]   mx;
   logic [61:0]   trial;
   logic [45:0]   dshift;
   logic signed [63:0] vin [3];

   assign res   = res_ff;
   assign vin[0] = vec_x;
   assign vin[1] = vec_y;
   assign vin[2] = vec_z;
   assign trial  = root_ff + bit_ff;
   assign dshift = 46'(root_ff[30:0]) << k_ff;

   always_comb begin
      mx = m_ff[0];
      if (m_ff[1] > mx) begin
         mx = m_ff[1];
      end
      if (m_ff[2] > mx) begin
         mx = m_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= N_IDLE;
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= 1'b0;
         case (state_ff)
            N_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= vin[i] < 0;
                     m_ff[i]   <= vin[i] < 0 ? 63'(-vin[i]) : 63'(vin[i]);
                  end
                  state_ff <= N_SHIFT;
               end
            end
            N_SHIFT: begin
               // bring the largest magnitude into [2^29, 2^30)
               if (mx == 63'd0) begin
                  res_ff.valid      <= 1'b1;
                  res_ff.degenerate <= 1'b1;
                  res_ff.nx         <= '0;
                  res_ff.ny         <= '0;
                  res_ff.nz         <= '0;
                  state_ff          <= N_IDLE;
               end else if (mx >= T38) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 8;
               end else if (mx >= T30) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
               end else if (mx < T22) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 8;
               end else if (mx < T29) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
               end else begin
                  step_ff  <= 2'd0;
                  x_ff     <= '0;
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               if (step_ff != 2'd3) begin
                  sq_ff <= m_ff[step_ff][29:0] * m_ff[step_ff][29:0];
               end
               if (step_ff != 2'd0) begin
                  x_ff <= x_ff + 62'(sq_ff);
               end
               if (step_ff == 2'd3) begin
                  root_ff  <= '0;
                  bit_ff   <= 62'(1) << 60;
                  state_ff <= N_SQRT;
               end
               step_ff <= step_ff + 2'd1;
            end
            N_SQRT: begin
               // one result bit per beat of the digit recurrence
               if (x_ff >= trial) begin
                  x_ff    <= x_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  state_ff <= N_PREP;
               end
            end
            N_PREP: begin
               for (int i = 0; i < 3; i++) begin
                  rem_ff[i] <= {1'b0, m_ff[i][29:0], 14'd0} + 45'(root_ff[30:1]);
                  q_ff[i]   <= '0;
               end
               k_ff     <= 4'd14;
               state_ff <= N_DIV;
            end
            N_DIV: begin
               for (int i = 0; i < 3; i++) begin
                  if (46'(rem_ff[i]) >= dshift) begin
                     rem_ff[i]     <= rem_ff[i] - dshift[44:0];
                     q_ff[i][k_ff] <= 1'b1;
                  end
               end
               k_ff <= k_ff - 4'd1;
               if (k_ff == 4'd0) begin
                  state_ff <= N_OUT;
               end
            end
            N_OUT: begin
               res_ff.valid      <= 1'b1;
               res_ff.degenerate <= 1'b0;
               res_ff.nx <= neg_ff[0] ? -16'(q_ff[0]) : 16'(q_ff[0]);
               res_ff.ny <= neg_ff[1] ? -16'(q_ff[1]) : 16'(q_ff[1]);
               res_ff.nz <= neg_ff[2] ? -16'(q_ff[2]) : 16'(q_ff[2]);
               state_ff  <= N_IDLE;
            end
            default: begin
               state_ff <= N_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/svna_back.sv =====
// back end: vertex and sum memories, triangle sequencer and result register
module svna_back #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   output logic                   init_done,
   input  logic                   q_valid,
   input  svna_pkg::svna_cmd_type q_cmd,
   output logic                   q_pop,
   output logic                   norm_start,
   output logic signed [63:0]     vec_x,
   output logic signed [63:0]     vec_y,
   output logic signed [63:0]     vec_z,
   input  svna_pkg::svna_nres_type nres,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output svna_pkg::svna_rsp_type rsp_data
);
   import svna_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = COORD_BITS;
   localparam int EW = COORD_BITS + 1;
   localparam logic [AW-1:0] LastAddr = AW'(MAX_VERTICES - 1);
   localparam logic [63:0]   Big = 64'(1) << 30;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_SUM,
      S_RD_START,
      S_RD_WAIT,
      S_RESULT,
      S_TRI_A,
      S_TRI_B,
      S_TRI_C,
      S_EDGE,
      S_SCALE,
      S_CROSS,
      S_TRI_START,
      S_TRI_WAIT,
      S_UPD_RD,
      S_UPD_WR
   } bstate_type;

   logic [3*CW-1:0] vert_mem [MAX_VERTICES];
   logic [59:0]     sum_mem  [MAX_VERTICES];

   bstate_type      state_ff;
   svna_cmd_type    cmd_ff;
   logic [AW-1:0]   clr_ff;
   logic [3*CW-1:0] vert_rd_ff, va_ff, vb_ff;
   logic [59:0]     sum_rd_ff;
   logic signed [EW-1:0] e1_ff [3], e2_ff [3];
   logic signed [61:0]   p1_ff, p2_ff;
   logic signed [63:0]   cr_ff [3];
   logic [1:0]      step_ff, sel_ff;
   logic signed [15:0] n_ff [3];
   logic            rsp_valid_ff;
   svna_rsp_type    rsp_ff, res_ff;

   logic            vert_we, sum_we;
   logic [AW-1:0]   vert_waddr, vert_raddr, sum_waddr, sum_raddr;
   logic [3*CW-1:0] vert_wdata;
   logic [59:0]     sum_wdata;
   logic [9:0]      corner;
   logic            distinct, any_big;
   logic signed [CW-1:0] ca [3], cb [3], cc [3];
   logic signed [30:0]   o1 [3], o2 [3];
   logic signed [19:0]   sat [3];

   assign init_done = state_ff != S_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (vert_we) begin
         vert_mem[vert_waddr] <= vert_wdata;
      end
      vert_rd_ff <= vert_mem[vert_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ca[i] = va_ff[(3-i)*CW-1 -: CW];
         cb[i] = vb_ff[(3-i)*CW-1 -: CW];
         cc[i] = vert_rd_ff[(3-i)*CW-1 -: CW];
         o1[i] = 31'(e1_ff[i]);
         o2[i] = 31'(e2_ff[i]);
      end
   end

   always_comb begin
      any_big = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if ((e1_ff[i] < 0 ? -64'(e1_ff[i]) : 64'(e1_ff[i])) >= Big) any_big = 1'b1;
         if ((e2_ff[i] < 0 ? -64'(e2_ff[i]) : 64'(e2_ff[i])) >= Big) any_big = 1'b1;
      end
   end

   // corner for the current sum update, and whether it is a first occurrence
   always_comb begin
      case (sel_ff)
         2'd0: begin
            corner   = cmd_ff.corner_a;
            distinct = 1'b1;
         end
         2'd1: begin
            corner   = cmd_ff.corner_b;
            distinct = cmd_ff.corner_b != cmd_ff.corner_a;
         end
         2'd2: begin
            corner   = cmd_ff.corner_c;
            distinct = (cmd_ff.corner_c != cmd_ff.corner_a) &&
                       (cmd_ff.corner_c != cmd_ff.corner_b);
         end
         default: begin
            corner   = cmd_ff.corner_a;
            distinct = 1'b0;
         end
      endcase
   end

   always_comb begin
      logic signed [20:0] s;
      for (int i = 0; i < 3; i++) begin
         s = 21'(signed'(sum_rd_ff[(3-i)*20-1 -: 20])) + 21'(n_ff[i]);
         if (s > 21'sd524287) begin
            sat[i] = 20'sd524287;
         end else if (s < -21'sd524288) begin
            sat[i] = -20'sd524288;
         end else begin
            sat[i] = 20'(s);
         end
      end
   end

   always_comb begin
      vert_we    = 1'b0;
      vert_waddr = AW'(q_cmd.index);
      vert_wdata = {CW'(q_cmd.pos_x), CW'(q_cmd.pos_y), CW'(q_cmd.pos_z)};
      vert_raddr = AW'(cmd_ff.corner_a);
      sum_we     = 1'b0;
      sum_waddr  = AW'(q_cmd.index);
      sum_wdata  = '0;
      sum_raddr  = AW'(cmd_ff.index);
      case (state_ff)
         S_CLEAR: begin
            sum_we    = 1'b1;
            sum_waddr = clr_ff;
         end
         S_IDLE: begin
            if (q_valid && q_cmd.op == OP_WRITE) begin
               vert_we = 1'b1;
               sum_we  = 1'b1;
            end
         end
         S_TRI_B: begin
            vert_raddr = AW'(cmd_ff.corner_b);
         end
         S_TRI_C: begin
            vert_raddr = AW'(cmd_ff.corner_c);
         end
         S_UPD_RD: begin
            sum_raddr = AW'(corner);
         end
         S_UPD_WR: begin
            sum_we    = 1'b1;
            sum_waddr = AW'(corner);
            sum_wdata = {sat[0], sat[1], sat[2]};
         end
         default: begin
            vert_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      norm_start = 1'b0;
      vec_x      = cr_ff[0];
      vec_y      = cr_ff[1];
      vec_z      = cr_ff[2];
      if (state_ff == S_RD_START) begin
         norm_start = 1'b1;
         vec_x = 64'(signed'(sum_rd_ff[59:40]));
         vec_y = 64'(signed'(sum_rd_ff[39:20]));
         vec_z = 64'(signed'(sum_rd_ff[19:0]));
      end else if (state_ff == S_TRI_START) begin
         norm_start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the result state reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == LastAddr) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff <= q_cmd;
                  case (q_cmd.op)
                     OP_TRI:      state_ff <= S_TRI_A;
                     OP_READ:     state_ff <= S_RD_SUM;
                     OP_READ_BAD: begin
                        res_ff.out_index  <= q_cmd.index;
                        res_ff.norm_x     <= '0;
                        res_ff.norm_y     <= '0;
                        res_ff.norm_z     <= '0;
                        res_ff.degenerate <= 1'b1;
                        state_ff          <= S_RESULT;
                     end
                     default:     state_ff <= S_IDLE;
                  endcase
               end
            end
            S_RD_SUM:   state_ff <= S_RD_START;
            S_RD_START: state_ff <= S_RD_WAIT;
            S_RD_WAIT: begin
               if (nres.valid) begin
                  res_ff.out_index  <= cmd_ff.index;
                  res_ff.norm_x     <= nres.nx;
                  res_ff.norm_y     <= nres.ny;
                  res_ff.norm_z     <= nres.nz;
                  res_ff.degenerate <= nres.degenerate;
                  state_ff          <= S_RESULT;
               end
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_TRI_A: state_ff <= S_TRI_B;
            S_TRI_B: begin
               va_ff    <= vert_rd_ff;
               state_ff <= S_TRI_C;
            end
            S_TRI_C: begin
               vb_ff    <= vert_rd_ff;
               state_ff <= S_EDGE;
            end
            S_EDGE: begin
               for (int i = 0; i < 3; i++) begin
                  e1_ff[i] <= EW'(cb[i]) - EW'(ca[i]);
                  e2_ff[i] <= EW'(cc[i]) - EW'(ca[i]);
               end
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               // halve both edges, magnitude truncated, until all fit in 30 bits
               if (any_big) begin
                  for (int i = 0; i < 3; i++) begin
                     e1_ff[i] <= e1_ff[i] < 0 ? -((-e1_ff[i]) >>> 1) : e1_ff[i] >>> 1;
                     e2_ff[i] <= e2_ff[i] < 0 ? -((-e2_ff[i]) >>> 1) : e2_ff[i] >>> 1;
                  end
               end else begin
                  step_ff  <= 2'd0;
                  state_ff <= S_CROSS;
               end
            end
            S_CROSS: begin
               case (step_ff)
                  2'd0: begin
                     p1_ff <= o1[1] * o2[2];
                     p2_ff <= o1[2] * o2[1];
                  end
                  2'd1: begin
                     p1_ff <= o1[2] * o2[0];
                     p2_ff <= o1[0] * o2[2];
                  end
                  2'd2: begin
                     p1_ff <= o1[0] * o2[1];
                     p2_ff <= o1[1] * o2[0];
                  end
                  default: begin
                     state_ff <= S_TRI_START;
                  end
               endcase
               if (step_ff != 2'd0) begin
                  cr_ff[step_ff - 2'd1] <= 64'(p1_ff) - 64'(p2_ff);
               end
               step_ff <= step_ff + 2'd1;
            end
            S_TRI_START: state_ff <= S_TRI_WAIT;
            S_TRI_WAIT: begin
               if (nres.valid) begin
                  n_ff[0] <= nres.nx;
                  n_ff[1] <= nres.ny;
                  n_ff[2] <= nres.nz;
                  sel_ff  <= 2'd0;
                  state_ff <= nres.degenerate ? S_IDLE : S_UPD_RD;
               end
            end
            S_UPD_RD: begin
               if (distinct) begin
                  state_ff <= S_UPD_WR;
               end else if (sel_ff == 2'd2) begin
                  state_ff <= S_IDLE;
               end else begin
                  sel_ff <= sel_ff + 2'd1;
               end
            end
            S_UPD_WR: begin
               if (sel_ff == 2'd2) begin
                  state_ff <= S_IDLE;
               end else begin
                  sel_ff   <= sel_ff + 2'd1;
                  state_ff <= S_UPD_RD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/smooth_vertex_normal_accumulator.sv =====
// top level of the smooth vertex normal accumulator
// Keeps MAX_VERTICES vertex positions and per-vertex sums of unit face normals.
// A write beat stores a position and zeroes that vertex's sum; a triangle beat
// reads its three corners, forms the cross product and normalizes it, then,
// unless it is degenerate, adds it once to each distinct corner; a read beat
// normalizes one stored sum and returns one result beat, a degenerate one for
// an index out of range. The normalizer works in steps: a shift search, a sum
// of squares, a square root and a divider. A two-entry command queue lets
// requests be taken while the back end works. After reset a clearing pass over
// every address zeroes the sums, and no request is taken until it ends.
module smooth_vertex_normal_accumulator #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  svna_pkg::svna_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output svna_pkg::svna_rsp_type rsp_data
);
   import svna_pkg::*;

   logic               init_done, q_valid, q_pop, norm_start;
   svna_cmd_type       q_cmd;
   svna_nres_type      nres;
   logic signed [63:0] vec_x, vec_y, vec_z;

   svna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (init_done),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop)
   );

   svna_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec_x (vec_x),
      .vec_y (vec_y),
      .vec_z (vec_z),
      .res   (nres)
   );

   svna_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .init_done  (init_done),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .norm_start (norm_start),
      .vec_x      (vec_x),
      .vec_y      (vec_y),
      .vec_z      (vec_z),
      .nres       (nres),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
